@@ rtl/core/prlt_pkg.sv @@
// Shared types and constants of the pin reservation lock table.
package prlt_pkg;

    localparam int MAX_PINS   = 64;
    localparam int IDX_W      = 6;
    localparam int MASK_W     = 64;
    localparam int USERS_W    = 7;
    localparam int TOTAL_W    = 13;
    localparam int COUNT_W    = 7;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int GROUP_SIZE = 8;
    localparam int GRP_CNT_W  = 4;
    localparam int GRP_IDX_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM        = 3'd0,
        CMD_RELEASE      = 3'd1,
        CMD_CLAIM_MASK   = 3'd2,
        CMD_RELEASE_MASK = 3'd3,
        CMD_QUERY        = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_CLAIM_REFUSED = 2'd1,
        ST_RELEASE_EMPTY = 2'd2,
        ST_BATCH_REFUSED = 2'd3
    } status_t;

    typedef struct packed {
        logic claim_mode;
        logic release_mode;
        logic batch;
        logic lock;
        logic commit;
    } lane_ctrl_t;

endpackage

@@ rtl/core/prlt_req_if.sv @@
// Request channel of the pin reservation lock table.
interface prlt_req_if;
    import prlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    pin_index;
    logic [MASK_W-1:0]   pin_mask;
    logic                lock_req;

    modport source (output valid, output cmd, output pin_index, output pin_mask,
                    output lock_req, input ready);
    modport sink   (input valid, input cmd, input pin_index, input pin_mask,
                    input lock_req, output ready);
endinterface

@@ rtl/core/prlt_rsp_if.sv @@
// Response channel of the pin reservation lock table.
interface prlt_rsp_if;
    import prlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                pin_active;
    logic [IDX_W-1:0]    failing_pin;
    logic [TOTAL_W-1:0]  total_users;

    modport source (output valid, output status, output pin_active, output failing_pin,
                    output total_users, input ready);
    modport sink   (input valid, input status, input pin_active, input failing_pin,
                    input total_users, output ready);
endinterface

@@ rtl/core/prlt_lane.sv @@
// One pin lane: user count, lock flag, claim/release test and update.
module prlt_lane #(
    parameter int LANE_ID    = 0,
    parameter int USER_LIMIT = 125
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  prlt_pkg::lane_ctrl_t     ctrl,
    input  logic [prlt_pkg::IDX_W-1:0] pin_index,
    input  logic                     mask_bit,
    output logic                     chg,
    output logic                     fail,
    output logic                     active
);
    import prlt_pkg::*;

    logic [USERS_W-1:0] users_reg, users_next;
    logic               locked_reg, locked_next;
    logic               idx_hit;
    logic               sel;
    logic               nz;
    logic               claim_ok;

    assign idx_hit  = (pin_index == IDX_W'(LANE_ID));
    assign sel      = ctrl.batch ? mask_bit : idx_hit;
    assign nz       = (users_reg != '0);
    assign claim_ok = !locked_reg && (users_reg < USERS_W'(USER_LIMIT))
                      && !(ctrl.lock && nz);
    assign chg      = sel && ((ctrl.claim_mode && claim_ok) || (ctrl.release_mode && nz));
    assign fail     = sel && ctrl.claim_mode && !claim_ok;
    assign active   = idx_hit && nz;

    always_comb
    begin
        users_next  = users_reg;
        locked_next = locked_reg;
        if (ctrl.commit && chg)
        begin
            if (ctrl.claim_mode)
            begin
                users_next = users_reg + USERS_W'(1);
                if (ctrl.lock)
                begin
                    locked_next = 1'b1;
                end
            end
            else
            begin
                users_next  = users_reg - USERS_W'(1);
                locked_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            users_reg  <= '0;
            locked_reg <= 1'b0;
        end
        else
        begin
            users_reg  <= users_next;
            locked_reg <= locked_next;
        end
    end

endmodule

@@ rtl/core/prlt_merge.sv @@
// Two-level merge of lane flags: change count and lowest refused pin.
module prlt_merge #(
    parameter int PIN_COUNT = 64
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [PIN_COUNT-1:0]         chg,
    input  logic [PIN_COUNT-1:0]         fail,
    output logic [prlt_pkg::COUNT_W-1:0] count,
    output logic                         any_fail,
    output logic [prlt_pkg::IDX_W-1:0]   first_fail
);
    import prlt_pkg::*;

    localparam int GROUPS = (PIN_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W  = GROUPS * GROUP_SIZE;

    logic [PAD_W-1:0]     chg_pad;
    logic [PAD_W-1:0]     fail_pad;
    logic [GRP_CNT_W-1:0] grp_cnt_next   [GROUPS];
    logic [GRP_CNT_W-1:0] grp_cnt_reg    [GROUPS];
    logic                 grp_fail_next  [GROUPS];
    logic                 grp_fail_reg   [GROUPS];
    logic [GRP_IDX_W-1:0] grp_first_next [GROUPS];
    logic [GRP_IDX_W-1:0] grp_first_reg  [GROUPS];

    assign chg_pad  = PAD_W'(chg);
    assign fail_pad = PAD_W'(fail);

    // first level: per group of eight lanes
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_cnt_next[g]   = '0;
            grp_fail_next[g]  = 1'b0;
            grp_first_next[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--)
            begin
                grp_cnt_next[g] = grp_cnt_next[g] + GRP_CNT_W'(chg_pad[g*GROUP_SIZE + b]);
                if (fail_pad[g*GROUP_SIZE + b])
                begin
                    grp_fail_next[g]  = 1'b1;
                    grp_first_next[g] = GRP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_cnt_reg[g]   <= grp_cnt_next[g];
                grp_fail_reg[g]  <= grp_fail_next[g];
                grp_first_reg[g] <= grp_first_next[g];
            end
        end
    end

    // second level: over the registered group results
    always_comb
    begin
        count      = '0;
        any_fail   = 1'b0;
        first_fail = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            count = count + COUNT_W'(grp_cnt_reg[g]);
            if (grp_fail_reg[g])
            begin
                any_fail   = 1'b1;
                first_fail = {GRP_IDX_W'(g), grp_first_reg[g]};
            end
        end
    end

endmodule

@@ rtl/core/pin_reservation_lock_table.sv @@
// Top level of the pin reservation lock table: sequencer, lanes, merge and result register.
//
// The block keeps one lane per pin (PIN_COUNT lanes), each holding a 7-bit user count
// and an exclusive-lock flag in flip-flops, plus a 13-bit total of all users. One
// request is handled at a time: the edge that accepts the request latches it; in
// S_EVAL all lanes test their pin in parallel and the merge stage registers
// per-group (eight lanes) change counts and refused flags; in S_MERGE the group
// results are summed, the lowest refused pin is picked and the lanes commit (a
// refused batch claim commits nothing); in S_RESULT the result, with pin_active
// read from the updated table, moves to the response register. A new request is
// taken only once the last one has left S_RESULT, also while an earlier response
// still waits in the response register; the sequencer only holds in its last step
// when that register is still full. Reset clears the whole table at once.
module pin_reservation_lock_table #(
    parameter int PIN_COUNT  = 64,
    parameter int USER_LIMIT = 125
) (
    input  logic       clk,
    input  logic       rst_n,
    prlt_req_if.sink   req,
    prlt_rsp_if.source rsp
);
    import prlt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MERGE,
        S_RESULT
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                lock_reg;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    failing_reg, failing_next;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_active_reg;
    logic [IDX_W-1:0]    rsp_failing_reg;
    logic [TOTAL_W-1:0]  rsp_total_reg;

    lane_ctrl_t             ctrl;
    logic [PIN_COUNT-1:0]   chg_vec;
    logic [PIN_COUNT-1:0]   fail_vec;
    logic [PIN_COUNT-1:0]   active_vec;
    logic [COUNT_W-1:0]     count;
    logic                   any_fail;
    logic [IDX_W-1:0]       first_fail;
    logic                   req_accept;
    logic                   rsp_free;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    // Decode the held request for the lanes; commit only in the merge step.
    always_comb
    begin
        ctrl.claim_mode   = (cmd_reg == CMD_CLAIM) || (cmd_reg == CMD_CLAIM_MASK);
        ctrl.release_mode = (cmd_reg == CMD_RELEASE) || (cmd_reg == CMD_RELEASE_MASK);
        ctrl.batch        = (cmd_reg == CMD_CLAIM_MASK) || (cmd_reg == CMD_RELEASE_MASK);
        ctrl.lock         = lock_reg;
        ctrl.commit       = (state_reg == S_MERGE)
                            && !((cmd_reg == CMD_CLAIM_MASK) && any_fail);
    end

    for (genvar i = 0; i < PIN_COUNT; i++)
    begin : g_lane
        prlt_lane #(
            .LANE_ID    (i),
            .USER_LIMIT (USER_LIMIT)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pin_index (idx_reg),
            .mask_bit  (mask_reg[i]),
            .chg       (chg_vec[i]),
            .fail      (fail_vec[i]),
            .active    (active_vec[i])
        );
    end

    prlt_merge #(
        .PIN_COUNT (PIN_COUNT)
    ) u_merge (
        .clk        (clk),
        .load       (state_reg == S_EVAL),
        .chg        (chg_vec),
        .fail       (fail_vec),
        .count      (count),
        .any_fail   (any_fail),
        .first_fail (first_fail)
    );

    // Status, failing pin and new total from the merged lane flags.
    always_comb
    begin
        status_next  = ST_OK;
        failing_next = '0;
        case (cmd_reg)
            CMD_CLAIM:
            begin
                if (count == '0)
                begin
                    status_next = ST_CLAIM_REFUSED;
                end
            end
            CMD_RELEASE:
            begin
                if (count == '0)
                begin
                    status_next = ST_RELEASE_EMPTY;
                end
            end
            CMD_CLAIM_MASK:
            begin
                if (any_fail)
                begin
                    status_next  = ST_BATCH_REFUSED;
                    failing_next = first_fail;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        total_next = total_reg;
        if (ctrl.commit)
        begin
            if (ctrl.claim_mode)
            begin
                total_next = total_reg + TOTAL_W'(count);
            end
            else if (ctrl.release_mode)
            begin
                total_next = total_reg - TOTAL_W'(count);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            idx_reg         <= '0;
            mask_reg        <= '0;
            lock_reg        <= 1'b0;
            total_reg       <= '0;
            status_reg      <= '0;
            failing_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= '0;
            rsp_active_reg  <= 1'b0;
            rsp_failing_reg <= '0;
            rsp_total_reg   <= '0;
        end
        else
        begin
            // drop the response once taken; the result step reloads it on its own
            if (rsp_valid_reg && rsp.ready && (state_reg != S_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        cmd_reg   <= req.cmd;
                        idx_reg   <= req.pin_index;
                        mask_reg  <= req.pin_mask;
                        lock_reg  <= req.lock_req;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    total_reg   <= total_next;
                    status_reg  <= status_next;
                    failing_reg <= failing_next;
                    state_reg   <= S_RESULT;
                end
                S_RESULT:
                begin
                    // hold until the response register is free
                    if (rsp_free)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_status_reg  <= status_reg;
                        rsp_active_reg  <= |active_vec;
                        rsp_failing_reg <= failing_reg;
                        rsp_total_reg   <= total_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.pin_active  = rsp_active_reg;
    assign rsp.failing_pin = rsp_failing_reg;
    assign rsp.total_users = rsp_total_reg;

endmodule

@@ rtl/core/prlt_checker.sv @@
// Port-level checks of the pin reservation lock table and their binding.
module prlt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [prlt_pkg::STATUS_W-1:0] status,
    input logic                          pin_active,
    input logic [prlt_pkg::IDX_W-1:0]    failing_pin,
    input logic [prlt_pkg::TOTAL_W-1:0]  total_users
);
    import prlt_pkg::*;

    // one request in flight: ready drops right after an accepted request
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_failing_only_batch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_BATCH_REFUSED) |-> (failing_pin == '0))
        else $error("failing pin reported outside a refused batch claim");

    a_refused_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_RELEASE_EMPTY) |-> !pin_active)
        else $error("refused release reports an active pin");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (total_users <= TOTAL_W'(MAX_PINS * 125)))
        else $error("user total beyond table capacity");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_users))
        else $error("stalled response changed");

endmodule

bind pin_reservation_lock_table prlt_checker u_prlt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .pin_active  (rsp.pin_active),
    .failing_pin (rsp.failing_pin),
    .total_users (rsp.total_users)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the pin reservation lock table: queued stimulus, driver, checker.
module testbench;
    import prlt_pkg::*;

    // Block configuration under test and run controls.
    localparam int PIN_TOTAL       = 64;
    localparam int USER_CAP        = 125;
    localparam int CMD_UNDEF_FIRST = 5;
    localparam int CMD_UNDEF_LAST  = 7;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_HOLD       = 160;
    localparam int HOLD_AFTER      = 200;
    localparam int CALM_TAIL       = 300;
    localparam logic [MASK_W-1:0] ALL_PINS = '1;

    // One request as queued for the driver; settle asks the driver to wait for an empty pipe.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
        logic              lock;
        logic              settle;
    } pin_request_t;

    // One expected response.
    typedef struct packed {
        status_t            status;
        logic               active;
        logic [IDX_W-1:0]   failing;
        logic [TOTAL_W-1:0] total;
    } pin_answer_t;

    logic clk;
    logic rst_n;

    prlt_req_if req_bus ();
    prlt_rsp_if rsp_bus ();

    pin_reservation_lock_table #(
        .PIN_COUNT  (PIN_TOTAL),
        .USER_LIMIT (USER_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the pin table.
    logic [USERS_W-1:0] seat_count [PIN_TOTAL];
    logic               pin_held   [PIN_TOTAL];
    logic [TOTAL_W-1:0] seat_sum;

    pin_request_t pending_requests [$];
    pin_answer_t  answers_due [$];
    pin_request_t next_request;
    pin_request_t taken_request;
    pin_answer_t  wanted;

    int requests_taken;
    int answers_seen;
    int request_total;
    int mismatch_count;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;
    int quiet_cycles;
    bit calm;

    // The last stretch of the run goes without idling on either side.
    assign calm = (requests_taken >= request_total - CALM_TAIL);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor of the pin table
    // ------------------------------------------------------------------

    // Test one pin against a claim: unlocked, below the user cap, and lock only on an idle pin.
    function automatic bit claim_allowed(int p, logic lock);
        if (p >= PIN_TOTAL)
            return 1'b0;
        if (pin_held[p])
            return 1'b0;
        if (lock && seat_count[p] != 0)
            return 1'b0;
        return seat_count[p] < USER_CAP;
    endfunction

    function automatic void take_seat(int p, logic lock);
        seat_count[p] = seat_count[p] + 1'b1;
        if (lock)
            pin_held[p] = 1'b1;
        seat_sum = seat_sum + 1'b1;
    endfunction

    function automatic void drop_seat(int p);
        seat_count[p] = seat_count[p] - 1'b1;
        pin_held[p] = 1'b0;
        seat_sum = seat_sum - 1'b1;
    endfunction

    // Apply one accepted request to the shadow table and return the response it must produce.
    function automatic pin_answer_t answer_request(pin_request_t r);
        pin_answer_t a;
        bit          refused;
        a.status  = ST_OK;
        a.failing = '0;
        refused   = 1'b0;
        case (r.cmd)
            CMD_CLAIM:
            begin
                if (claim_allowed(r.idx, r.lock))
                    take_seat(r.idx, r.lock);
                else
                    a.status = ST_CLAIM_REFUSED;
            end
            CMD_RELEASE:
            begin
                if (r.idx < PIN_TOTAL && seat_count[r.idx] != 0)
                    drop_seat(r.idx);
                else
                    a.status = ST_RELEASE_EMPTY;
            end
            CMD_CLAIM_MASK:
            begin
                // All or nothing: test every selected pin on the old state, report the lowest refusal.
                for (int p = 0; p < PIN_TOTAL; p++)
                begin
                    if (!refused && r.mask[p] && !claim_allowed(p, r.lock))
                    begin
                        refused   = 1'b1;
                        a.failing = IDX_W'(p);
                    end
                end
                if (refused)
                    a.status = ST_BATCH_REFUSED;
                else
                    for (int p = 0; p < PIN_TOTAL; p++)
                        if (r.mask[p])
                            take_seat(p, r.lock);
            end
            CMD_RELEASE_MASK:
            begin
                // Skip idle pins; the status stays OK.
                for (int p = 0; p < PIN_TOTAL; p++)
                    if (r.mask[p] && seat_count[p] != 0)
                        drop_seat(p);
            end
            default:
            begin
                // Query and the unused codes leave the table alone.
            end
        endcase
        a.active = (r.idx < PIN_TOTAL) && (seat_count[r.idx] != 0);
        a.total  = seat_sum;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic add_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic [MASK_W-1:0] mask, logic lock, logic settle);
        pin_request_t r;
        r.cmd    = cmd;
        r.idx    = idx;
        r.mask   = mask;
        r.lock   = lock;
        r.settle = settle;
        pending_requests.push_back(r);
    endtask

    // Favor the two ends of the table so single-pin traffic piles up on few pins.
    function automatic logic [IDX_W-1:0] hot_pin();
        case ($urandom_range(0, 2))
            0:       return IDX_W'($urandom_range(0, 3));
            1:       return IDX_W'($urandom_range(PIN_TOTAL - 4, PIN_TOTAL - 1));
            default: return IDX_W'($urandom_range(0, PIN_TOTAL - 1));
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask(logic [IDX_W-1:0] idx);
        case ($urandom_range(0, 5))
            0:       return {$urandom, $urandom};
            1:       return ALL_PINS;
            2:       return '0;
            3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            4:       return {{4{1'b1}}, {(MASK_W - 8){1'b0}}, {4{1'b1}}} & {$urandom, $urandom};
            default: return {{(MASK_W - 1){1'b0}}, 1'b1} << idx;
        endcase
    endfunction

    // Append one loose request with any command, unused codes included.
    task automatic add_mixed_request();
        int                pick;
        logic [IDX_W-1:0]  idx;
        logic [CMD_W-1:0]  cmd;
        pick = $urandom_range(0, 99);
        idx  = hot_pin();
        if (pick < 30)
            cmd = CMD_CLAIM;
        else if (pick < 52)
            cmd = CMD_RELEASE;
        else if (pick < 64)
            cmd = CMD_CLAIM_MASK;
        else if (pick < 74)
            cmd = CMD_RELEASE_MASK;
        else if (pick < 90)
            cmd = CMD_QUERY;
        else
            cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        add_request(cmd, idx, pick_mask(idx), $urandom_range(0, 3) == 0, 1'b0);
    endtask

    // Append a well-formed session: batch claim, look at one pin, claim it once more, release the batch mask.
    task automatic add_session();
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
        logic              lock;
        idx  = hot_pin();
        mask = pick_mask(idx) | ({{(MASK_W - 1){1'b0}}, 1'b1} << idx);
        lock = 1'($urandom_range(0, 1));
        add_request(CMD_CLAIM_MASK, idx, mask, lock, 1'b0);
        add_request(CMD_QUERY, idx, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, idx, '0, 1'($urandom_range(0, 1)), 1'b0);
        add_request(CMD_RELEASE_MASK, hot_pin(), mask, 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic add_random_until(int target);
        while (pending_requests.size() < target)
            if ($urandom_range(0, 4) == 0)
                add_session();
            else
                add_mixed_request();
    endtask

    // Fill every pin to the user cap and drain it again, probing the cap on the way.
    task automatic add_fill_and_drain();
        logic [IDX_W-1:0] pin;
        // Pause here until the pipe is empty, then wipe whatever the random part left.
        add_request(CMD_RELEASE_MASK, hot_pin(), ALL_PINS, 1'b0, 1'b1);
        repeat (USER_CAP)
            add_request(CMD_RELEASE_MASK, IDX_W'($urandom_range(0, PIN_TOTAL - 1)), ALL_PINS,
                        1'b0, 1'b0);
        repeat (USER_CAP + 2)
            add_request(CMD_CLAIM_MASK, IDX_W'($urandom_range(0, PIN_TOTAL - 1)), ALL_PINS,
                        1'b0, 1'b0);
        pin = IDX_W'($urandom_range(0, PIN_TOTAL - 1));
        add_request(CMD_CLAIM, pin, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, pin, '0, 1'b1, 1'b0);
        add_request(CMD_RELEASE, pin, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM_MASK, pin, {{(MASK_W - 1){1'b0}}, 1'b1} << pin, 1'b1, 1'b0);
        add_request(CMD_CLAIM, pin, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM_MASK, pin, {{(MASK_W - 1){1'b0}}, 1'b1} << pin, 1'b0, 1'b0);
        add_request(CMD_QUERY, pin, '0, 1'b0, 1'b0);
        repeat (USER_CAP + 1)
            add_request(CMD_RELEASE_MASK, IDX_W'($urandom_range(0, PIN_TOTAL - 1)), ALL_PINS,
                        1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Directed opening: empty table answers, locks, batch refusals and the unused codes.
    task automatic add_directed();
        logic [MASK_W-1:0] pin0, pin7, pin63;
        pin0  = {{(MASK_W - 1){1'b0}}, 1'b1};
        pin7  = pin0 << 7;
        pin63 = pin0 << 63;
        add_request(CMD_QUERY, 6'd0, '0, 1'b0, 1'b0);
        add_request(CMD_RELEASE, 6'd5, '0, 1'b1, 1'b0);
        add_request(CMD_RELEASE_MASK, 6'd63, ALL_PINS, 1'b0, 1'b0);
        add_request(CMD_CLAIM_MASK, 6'd0, '0, 1'b1, 1'b0);
        add_request(CMD_RELEASE_MASK, 6'd0, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, 6'd0, '0, 1'b1, 1'b0);
        add_request(CMD_CLAIM, 6'd0, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, 6'd63, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, 6'd63, '0, 1'b1, 1'b0);
        add_request(CMD_CLAIM_MASK, 6'd63, pin0 | pin7 | pin63, 1'b0, 1'b0);
        add_request(CMD_CLAIM_MASK, 6'd7, pin7 | pin63, 1'b1, 1'b0);
        add_request(CMD_CLAIM_MASK, 6'd63, ALL_PINS & ~pin0, 1'b0, 1'b0);
        add_request(CMD_RELEASE, 6'd0, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM, 6'd0, '0, 1'b0, 1'b0);
        add_request(CMD_W'(CMD_UNDEF_FIRST), 6'd0, ALL_PINS, 1'b1, 1'b0);
        add_request(CMD_W'(CMD_UNDEF_FIRST + 1), 6'd63, ALL_PINS, 1'b1, 1'b0);
        add_request(CMD_W'(CMD_UNDEF_LAST), 6'd42, '0, 1'b0, 1'b0);
        add_request(CMD_RELEASE_MASK, 6'd0, ALL_PINS, 1'b1, 1'b0);
        add_request(CMD_RELEASE_MASK, 6'd0, ALL_PINS, 1'b0, 1'b0);
        add_request(CMD_QUERY, 6'd63, '0, 1'b0, 1'b0);
        add_request(CMD_CLAIM_MASK, 6'd63, pin63, 1'b1, 1'b0);
        add_request(CMD_RELEASE, 6'd63, '0, 1'b1, 1'b0);
        add_request(CMD_RELEASE, 6'd63, '0, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Print one line per mismatch and count every one.
    task automatic flag_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("%0t mismatch: %s got %0d want %0d (response %0d)",
                 $realtime, what, got, want, answers_seen);
    endtask

    // ------------------------------------------------------------------
    // Request driver: pop the pending queue, hold each request until taken, idle in bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.cmd       <= CMD_QUERY;
            req_bus.pin_index <= '0;
            req_bus.pin_mask  <= '0;
            req_bus.lock_req  <= 1'b0;
            gap_left          <= 0;
        end
        else if (req_bus.valid && !req_bus.ready)
        begin
            // Hold the offered request until the block takes it.
        end
        else if (gap_left > 0)
        begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
        end
        else if (pending_requests.size() > 0 &&
                 (!pending_requests[0].settle ||
                  (!req_bus.valid && requests_taken == answers_seen)))
        begin
            next_request      = pending_requests.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.cmd       <= next_request.cmd;
            req_bus.pin_index <= next_request.idx;
            req_bus.pin_mask  <= next_request.mask;
            req_bus.lock_req  <= next_request.lock;
            // Start an idle burst after this request now and then.
            if (!calm && $urandom_range(0, 7) == 0)
                gap_left <= $urandom_range(1, 11);
        end
        else
            req_bus.valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Response ready: random stall bursts plus one long hold-off that backs up the block.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (!hold_done && requests_taken >= HOLD_AFTER)
        begin
            hold_done     <= 1'b1;
            hold_left     <= LONG_HOLD;
            rsp_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 10);
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: check each response against the oldest expectation, then predict new requests.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requests_taken <= 0;
            answers_seen   <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (answers_due.size() == 0)
                    flag_mismatch("response with nothing outstanding", 0, 0);
                else
                begin
                    wanted = answers_due.pop_front();
                    if (rsp_bus.status !== wanted.status)
                        flag_mismatch("status", longint'(rsp_bus.status),
                                      longint'(wanted.status));
                    if (rsp_bus.pin_active !== wanted.active)
                        flag_mismatch("pin_active", longint'(rsp_bus.pin_active),
                                      longint'(wanted.active));
                    if (rsp_bus.failing_pin !== wanted.failing)
                        flag_mismatch("failing_pin", longint'(rsp_bus.failing_pin),
                                      longint'(wanted.failing));
                    if (rsp_bus.total_users !== wanted.total)
                        flag_mismatch("total_users", longint'(rsp_bus.total_users),
                                      longint'(wanted.total));
                end
                answers_seen <= answers_seen + 1;
            end
            if (req_bus.valid && req_bus.ready)
            begin
                taken_request.cmd    = req_bus.cmd;
                taken_request.idx    = req_bus.pin_index;
                taken_request.mask   = req_bus.pin_mask;
                taken_request.lock   = req_bus.lock_req;
                taken_request.settle = 1'b0;
                answers_due.push_back(answer_request(taken_request));
                requests_taken <= requests_taken + 1;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, reset once, wait for the last response.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        mismatch_count    = 0;
        seat_sum          = '0;
        for (int p = 0; p < PIN_TOTAL; p++)
        begin
            seat_count[p] = '0;
            pin_held[p]   = 1'b0;
        end

        add_directed();
        add_random_until(620);
        add_fill_and_drain();
        add_random_until(1600);
        request_total = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and answered, then let the pipe run dry.
        while (requests_taken != request_total || answers_seen != requests_taken)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (answers_due.size() != 0)
            flag_mismatch("expectations left over", 0, answers_due.size());

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
